### rtl/core/wcrs_pkg.sv
// ----------------------------------------------------------------------------
// wcrs_pkg
// Shared types, constants and helpers of the WAV clip level spike detector.
// ----------------------------------------------------------------------------
package wcrs_pkg;

	localparam int NUM_SLOTS_DEF       = 8;
	localparam int CLIP_BYTES_LOG2_DEF = 24;

	localparam int SQRT_STEPS = 17;
	localparam int HDR_BYTES  = 44;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [15:0] MIN_LEVEL_RST   = 16'd9830;
	localparam logic [15:0] SPIKE_RATIO_RST = 16'd461;
	localparam logic [8:0]  NEW_WEIGHT_RST  = 9'd77;

	typedef enum logic [1:0] {
		REG_MIN_LEVEL   = 2'd0,
		REG_SPIKE_RATIO = 2'd1,
		REG_NEW_WEIGHT  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_NOT_WAVE = 3'd2,
		ERR_NOT_PCM  = 3'd3,
		ERR_MISSING  = 3'd4,
		ERR_NO_SMPL  = 3'd5,
		ERR_TOO_LONG = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		PH_HEADER    = 2'd0,
		PH_CHUNK_HDR = 2'd1,
		PH_BODY      = 2'd2,
		PH_STOP      = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		K_OTHER = 2'd0,
		K_FMT   = 2'd1,
		K_DATA  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_SQLD,
		ST_SQRT,
		ST_CMP,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic eval;
		logic div_load;
		logic div_step;
		logic sq_load;
		logic sq_step;
		logic cmp;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic err_ok;
		logic out_free;
	} sts_t;

	// Camera index reduced modulo the slot count by repeated subtraction.
	function automatic logic [7:0] slot_of(input logic [2:0] cam, input int ns);
		logic [2:0] r;
		r = cam;
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= ns) begin
				r = r - 3'(ns);
			end
		end
		return {5'd0, r};
	endfunction

endpackage

### rtl/core/wcrs_ctrl.sv
// ----------------------------------------------------------------------------
// wcrs_ctrl
// Sequencer: byte intake, evaluation, divide, square root, level update.
// ----------------------------------------------------------------------------
module wcrs_ctrl #(
	parameter int DIV_STEPS = wcrs_pkg::CLIP_BYTES_LOG2_DEF + 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	input  wcrs_pkg::sts_t  sts,
	output wcrs_pkg::cmd_t  cmd
);

	localparam int CW = $clog2(DIV_STEPS + 1);

	wcrs_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]    cnt_q, cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcrs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		cmd       = '0;
		unique case (state_q)
			wcrs_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid && in_last) begin
					state_nxt = wcrs_pkg::ST_EVAL;
				end
			end
			wcrs_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				cnt_nxt  = '0;
				if (sts.err_ok) begin
					cmd.div_load = 1'b1;
					state_nxt    = wcrs_pkg::ST_DIV;
				end else begin
					state_nxt = wcrs_pkg::ST_OUT;
				end
			end
			wcrs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_nxt      = cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) begin
					state_nxt = wcrs_pkg::ST_SQLD;
				end
			end
			wcrs_pkg::ST_SQLD: begin
				cmd.sq_load = 1'b1;
				cnt_nxt     = '0;
				state_nxt   = wcrs_pkg::ST_SQRT;
			end
			wcrs_pkg::ST_SQRT: begin
				cmd.sq_step = 1'b1;
				cnt_nxt     = cnt_q + 1'b1;
				if (cnt_q == CW'(wcrs_pkg::SQRT_STEPS - 1)) begin
					state_nxt = wcrs_pkg::ST_CMP;
				end
			end
			wcrs_pkg::ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = wcrs_pkg::ST_UPD;
			end
			wcrs_pkg::ST_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = wcrs_pkg::ST_OUT;
			end
			wcrs_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = wcrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = wcrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/wcrs_datapath.sv
// ----------------------------------------------------------------------------
// wcrs_datapath
// Chunk parser, sample accumulator, divider, square root, level table and
// result register.
// ----------------------------------------------------------------------------
module wcrs_datapath #(
	parameter int NUM_SLOTS       = wcrs_pkg::NUM_SLOTS_DEF,
	parameter int CLIP_BYTES_LOG2 = wcrs_pkg::CLIP_BYTES_LOG2_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wcrs_pkg::cmd_t cmd,
	output wcrs_pkg::sts_t sts,
	input  logic           byte_en,
	input  logic [7:0]     data_byte,
	input  logic [2:0]     camera,
	input  logic           cfg_en,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [47:0]    out_data
);

	localparam int CBL    = CLIP_BYTES_LOG2;
	localparam int SW     = CBL + 30;
	localparam int DW     = SW + 2;
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Configuration registers.
	logic [15:0] min_level_q, spike_ratio_q;
	logic [8:0]  new_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q   <= wcrs_pkg::MIN_LEVEL_RST;
			spike_ratio_q <= wcrs_pkg::SPIKE_RATIO_RST;
			new_weight_q  <= wcrs_pkg::NEW_WEIGHT_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				wcrs_pkg::REG_MIN_LEVEL:   min_level_q   <= cfg_data;
				wcrs_pkg::REG_SPIKE_RATIO: spike_ratio_q <= cfg_data;
				wcrs_pkg::REG_NEW_WEIGHT:  new_weight_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Per-clip parser state.
	wcrs_pkg::phase_t phase_q, n_phase;
	wcrs_pkg::kind_t  kind_q, n_kind;
	logic [CBL-1:0]   clip_q, n_clip;
	logic [31:0]      tag_q, n_tag;
	logic [31:0]      len_q, n_len;
	logic [32:0]      pos_q, n_pos;
	logic [63:0]      fmt_q, n_fmt;
	logic [63:0]      pf_q, n_pf;
	logic [15:0]      pa_q, n_pa;
	logic [15:0]      dbits_q, n_dbits;
	logic [SW-1:0]    csum_q, n_csum, psum_q, n_psum;
	logic [CBL-1:0]   ccnt_q, n_ccnt, pcnt_q, n_pcnt;
	logic [7:0]       lh_q, n_lh;
	logic             ovl_q, n_ovl, hbad_q, n_hbad, fbad_q, n_fbad;
	logic             fseen_q, n_fseen, dpres_q, n_dpres, dempty_q, n_dempty;

	always_comb begin
		logic [31:0]            tg, ln;
		logic [63:0]            pf;
		logic [15:0]            pa, db;
		logic [SW-1:0]          ps;
		logic [CBL-1:0]         pc;
		logic [32:0]            span;
		logic                   do_close;
		wcrs_pkg::kind_t        kd;
		logic signed [15:0]     smp;
		logic signed [31:0]     sq;
		logic                   add;

		n_phase = phase_q; n_kind = kind_q; n_clip = clip_q; n_tag = tag_q;
		n_len = len_q; n_pos = pos_q; n_fmt = fmt_q; n_pf = pf_q; n_pa = pa_q;
		n_dbits = dbits_q; n_csum = csum_q; n_psum = psum_q; n_ccnt = ccnt_q;
		n_pcnt = pcnt_q; n_lh = lh_q; n_ovl = ovl_q; n_hbad = hbad_q;
		n_fbad = fbad_q; n_fseen = fseen_q; n_dpres = dpres_q; n_dempty = dempty_q;
		tg = tag_q; ln = len_q; pf = pf_q; pa = pa_q; db = dbits_q;
		ps = psum_q; pc = pcnt_q; kd = kind_q; do_close = 1'b0;
		smp = '0; add = 1'b0;
		span = {1'b0, len_q} + 33'(len_q[0]);

		if (byte_en && !ovl_q) begin
			if (&clip_q) begin
				n_ovl = 1'b1;
			end else begin
				n_clip = clip_q + 1'b1;
				case (phase_q)
					wcrs_pkg::PH_HEADER: begin
						tg    = {tag_q[23:0], data_byte};
						n_tag = tg;
						if (clip_q == CBL'(3) && tg != wcrs_pkg::TAG_RIFF) begin
							n_hbad = 1'b1;
						end
						if (clip_q == CBL'(11)) begin
							if (tg != wcrs_pkg::TAG_WAVE) begin
								n_hbad = 1'b1;
							end
							n_tag   = '0;
							n_pos   = '0;
							n_len   = '0;
							n_phase = wcrs_pkg::PH_CHUNK_HDR;
						end
					end
					wcrs_pkg::PH_CHUNK_HDR: begin
						if (pos_q < 33'd4) begin
							tg = {tag_q[23:0], data_byte};
						end else begin
							ln[8*pos_q[1:0] +: 8] = data_byte;
						end
						n_tag = tg;
						n_len = ln;
						n_pos = pos_q + 1'b1;
						if (pos_q == 33'd7) begin
							kd = wcrs_pkg::K_OTHER;
							if (tg == wcrs_pkg::TAG_FMT && ln >= 32'd16) begin
								kd = wcrs_pkg::K_FMT;
							end else if (tg == wcrs_pkg::TAG_DATA) begin
								kd = wcrs_pkg::K_DATA;
								ps = '0;
								pc = '0;
								if (!fseen_q) begin
									db = '0;
								end else if (fmt_q[63:48] == 16'd0) begin
									db = 16'hFFFF;
								end else begin
									db = fmt_q[63:48];
								end
							end
							n_kind  = kd;
							n_dbits = db;
							n_psum  = ps;
							n_pcnt  = pc;
							n_pos   = '0;
							n_phase = wcrs_pkg::PH_BODY;
							if (ln == 32'd0) begin
								do_close = 1'b1;
							end
						end
					end
					wcrs_pkg::PH_BODY: begin
						if (kind_q == wcrs_pkg::K_FMT) begin
							if (pos_q < 33'd2) begin
								pa[8*pos_q[0] +: 8] = data_byte;
							end else if (pos_q < 33'd8) begin
								pf[8*(pos_q[2:0] - 3'd2) +: 8] = data_byte;
							end else if (pos_q == 33'd14) begin
								pf[55:48] = data_byte;
							end else if (pos_q == 33'd15) begin
								pf[63:56] = data_byte;
							end
						end else if (kind_q == wcrs_pkg::K_DATA && pos_q < {1'b0, len_q}) begin
							if (dbits_q == 16'd8) begin
								smp = {~data_byte[7], data_byte[6:0], 8'h00};
								add = 1'b1;
							end else if (dbits_q == 16'd16) begin
								if (!pos_q[0]) begin
									n_lh = data_byte;
								end else begin
									smp = {data_byte, lh_q};
									add = 1'b1;
								end
							end
						end
						sq = smp * smp;
						if (add) begin
							ps = psum_q + SW'(sq[30:0]);
							pc = pcnt_q + 1'b1;
						end
						n_pa   = pa;
						n_pf   = pf;
						n_psum = ps;
						n_pcnt = pc;
						n_pos  = pos_q + 1'b1;
						if (pos_q + 1'b1 == span) begin
							do_close = 1'b1;
						end
					end
					default: ;
				endcase

				if (do_close) begin
					if (kd == wcrs_pkg::K_FMT && pa != 16'd1) begin
						n_fbad  = 1'b1;
						n_phase = wcrs_pkg::PH_STOP;
					end else begin
						if (kd == wcrs_pkg::K_FMT) begin
							n_fmt   = pf;
							n_fseen = 1'b1;
						end else if (kd == wcrs_pkg::K_DATA && db != 16'd0) begin
							n_csum   = ps;
							n_ccnt   = pc;
							n_dpres  = 1'b1;
							n_dempty = (ln == 32'd0);
						end
						n_tag   = '0;
						n_len   = '0;
						n_pos   = '0;
						n_pa    = '0;
						n_pf    = '0;
						n_kind  = wcrs_pkg::K_OTHER;
						n_phase = wcrs_pkg::PH_CHUNK_HDR;
					end
				end
			end
		end

		if (cmd.out_load) begin
			n_phase = wcrs_pkg::PH_HEADER; n_kind = wcrs_pkg::K_OTHER; n_clip = '0;
			n_tag = '0; n_len = '0; n_pos = '0; n_fmt = '0; n_pf = '0; n_pa = '0;
			n_dbits = '0; n_csum = '0; n_psum = '0; n_ccnt = '0; n_pcnt = '0;
			n_lh = '0; n_ovl = 1'b0; n_hbad = 1'b0; n_fbad = 1'b0; n_fseen = 1'b0;
			n_dpres = 1'b0; n_dempty = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wcrs_pkg::PH_HEADER; kind_q <= wcrs_pkg::K_OTHER; clip_q <= '0;
			tag_q <= '0; len_q <= '0; pos_q <= '0; fmt_q <= '0; pf_q <= '0; pa_q <= '0;
			dbits_q <= '0; csum_q <= '0; psum_q <= '0; ccnt_q <= '0; pcnt_q <= '0;
			lh_q <= '0; ovl_q <= 1'b0; hbad_q <= 1'b0; fbad_q <= 1'b0; fseen_q <= 1'b0;
			dpres_q <= 1'b0; dempty_q <= 1'b0;
		end else begin
			phase_q <= n_phase; kind_q <= n_kind; clip_q <= n_clip;
			tag_q <= n_tag; len_q <= n_len; pos_q <= n_pos; fmt_q <= n_fmt; pf_q <= n_pf;
			pa_q <= n_pa; dbits_q <= n_dbits; csum_q <= n_csum; psum_q <= n_psum;
			ccnt_q <= n_ccnt; pcnt_q <= n_pcnt; lh_q <= n_lh; ovl_q <= n_ovl;
			hbad_q <= n_hbad; fbad_q <= n_fbad; fseen_q <= n_fseen;
			dpres_q <= n_dpres; dempty_q <= n_dempty;
		end
	end

	// Error classification on the finished clip, in priority order.
	wcrs_pkg::err_t err_c, err_q;
	logic [15:0]    chan;
	logic [31:0]    rate;
	logic [15:0]    bits;

	assign chan = fmt_q[15:0];
	assign rate = fmt_q[47:16];
	assign bits = fmt_q[63:48];

	always_comb begin
		if (ovl_q) begin
			err_c = wcrs_pkg::ERR_TOO_LONG;
		end else if (clip_q < CBL'(wcrs_pkg::HDR_BYTES)) begin
			err_c = wcrs_pkg::ERR_SHORT;
		end else if (hbad_q) begin
			err_c = wcrs_pkg::ERR_NOT_WAVE;
		end else if (fbad_q) begin
			err_c = wcrs_pkg::ERR_NOT_PCM;
		end else if (!fseen_q || chan == 16'd0 || rate == 32'd0 || rate[31]
		             || (bits != 16'd8 && bits != 16'd16) || !dpres_q || dempty_q) begin
			err_c = wcrs_pkg::ERR_MISSING;
		end else if (ccnt_q == '0) begin
			err_c = wcrs_pkg::ERR_NO_SMPL;
		end else begin
			err_c = wcrs_pkg::ERR_OK;
		end
	end

	assign sts.err_ok = (err_c == wcrs_pkg::ERR_OK);

	logic [SLOT_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (byte_en) begin
			slot_q <= SLOT_W'(wcrs_pkg::slot_of(camera, NUM_SLOTS));
		end
		if (cmd.eval) begin
			err_q <= err_c;
		end
	end

	// Restoring divider: 4 * sum / samples, one dividend bit per cycle.
	// The quotient never exceeds 2^32, so 33 quotient bits are kept.
	logic [DW-1:0]  dvd_q;
	logic [CBL-1:0] rem_q;
	logic [32:0]    quo_q;

	always_ff @(posedge clk) begin
		logic [CBL:0] sh;
		sh = {rem_q, dvd_q[DW-1]};
		if (cmd.div_load) begin
			dvd_q <= {csum_q, 2'b00};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (sh >= {1'b0, ccnt_q}) begin
				rem_q <= CBL'(sh - {1'b0, ccnt_q});
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= sh[CBL-1:0];
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	// Digit-by-digit square root, two radicand bits per cycle.
	logic [33:0] rad_q;
	logic [19:0] srem_q;
	logic [16:0] root_q;

	always_ff @(posedge clk) begin
		logic [19:0] shr;
		logic [19:0] trial;
		shr   = {srem_q[17:0], rad_q[33:32]};
		trial = {1'b0, root_q, 2'b01};
		if (cmd.sq_load) begin
			rad_q  <= {1'b0, quo_q};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q <= {rad_q[31:0], 2'b00};
			if (shr >= trial) begin
				srem_q <= shr - trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				srem_q <= shr;
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	logic [15:0] score;
	assign score = root_q[16] ? 16'hFFFF : root_q[15:0];

	// Level table and spike decision.
	logic [15:0] lvl_q [NUM_SLOTS];
	logic [15:0] prev;
	logic        det_q;
	logic [8:0]  w;
	logic [31:0] base_prod;
	logic [25:0] mix;

	assign prev      = lvl_q[slot_q];
	assign w         = (new_weight_q > 9'd256) ? 9'd256 : new_weight_q;
	assign base_prod = spike_ratio_q * prev;
	assign mix       = 26'(prev * (9'd256 - w)) + 26'(score * w) + 26'd128;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			det_q <= (score >= min_level_q)
			         && (prev == 16'd0 || {score, 8'h00} >= {8'h00, base_prod});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				lvl_q[i] <= '0;
			end
		end else if (cmd.upd) begin
			lvl_q[slot_q] <= (prev == 16'd0) ? score : mix[23:8];
		end
	end

	// Result register.
	logic        ovalid_q;
	logic [47:0] odata_q;
	logic        ok;

	assign ok           = (err_q == wcrs_pkg::ERR_OK);
	assign sts.out_free = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			odata_q <= {4'd0, 24'(clip_q), err_q, ok & det_q, ok ? score : 16'd0};
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

endmodule

### rtl/core/wav_clip_rms_spike_detector.sv
// ----------------------------------------------------------------------------
// wav_clip_rms_spike_detector
// RIFF/WAVE PCM clip parser with RMS level and per-camera spike detection.
// ----------------------------------------------------------------------------
// Clip bytes are taken one per cycle while s_tready is high. The final byte
// (tlast) starts the evaluation, during which no bytes are taken: the clip
// is classified, then taken through the bit-serial divider, loaded into and
// stepped through the two-bits-per-cycle square root, the level is compared
// and the table updated, and the result register is loaded once the output
// is free. A clip with an error skips the arithmetic and goes from its
// classification straight to loading the result register. The next clip
// may start while a result waits.
// ----------------------------------------------------------------------------
module wav_clip_rms_spike_detector #(
	parameter int NUM_SLOTS       = wcrs_pkg::NUM_SLOTS_DEF,
	parameter int CLIP_BYTES_LOG2 = wcrs_pkg::CLIP_BYTES_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	input  logic [2:0]  s_tuser,   // camera
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // score, detected, error_code, byte_count, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	wcrs_pkg::cmd_t cmd;
	wcrs_pkg::sts_t sts;

	assign s_tready  = cmd.in_ready;
	assign cfg_ready = 1'b1;

	wcrs_ctrl #(
		.DIV_STEPS(CLIP_BYTES_LOG2 + 32)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_last (s_tlast),
		.sts     (sts),
		.cmd     (cmd)
	);

	wcrs_datapath #(
		.NUM_SLOTS      (NUM_SLOTS),
		.CLIP_BYTES_LOG2(CLIP_BYTES_LOG2)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.byte_en  (s_tvalid & cmd.in_ready),
		.data_byte(s_tdata),
		.camera   (s_tuser),
		.cfg_en   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

### tb/wav_clip_checker.sv
// ----------------------------------------------------------------------------
// wav_clip_checker
// Watches the byte, result and register channels of the WAV clip spike
// detector, parses each clip on its own and checks every result.
// ----------------------------------------------------------------------------
module wav_clip_checker
	import wcrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          pending,
	output int          fails,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] CLIP_MAX = (64'd1 << CLIP_BYTES_LOG2_DEF) - 1;

	typedef struct {
		logic [15:0] score;
		logic        detected;
		err_t        code;
		logic [23:0] count;
	} clip_report_t;

	clip_report_t reports[$];

	logic [15:0] min_lvl, ratio;
	logic [8:0]  weight;
	logic [15:0] levels[8];

	phase_t      phase;
	kind_t       kind;
	logic [63:0] nbytes, cpos, fmtf, pfields, csum, psum, csamp, psamp;
	logic [31:0] tag, clen;
	logic [15:0] paudio, dbits;
	logic [7:0]  lowh;
	logic        not_pcm, hbad, ovl, fseen, dpres, dempty;
	int          nfail, nchecked;

	task automatic clear_clip();
		phase = PH_HEADER;
		kind = K_OTHER;
		nbytes = 0; cpos = 0; fmtf = 0; pfields = 0;
		csum = 0; psum = 0; csamp = 0; psamp = 0;
		tag = 0; clen = 0; paudio = 0; dbits = 0; lowh = 0;
		not_pcm = 0; hbad = 0; ovl = 0; fseen = 0; dpres = 0; dempty = 0;
	endtask

	function automatic logic [63:0] chunk_span();
		return 64'(clen) + 64'(clen[0]);
	endfunction

	task automatic close_chunk();
		if (kind == K_FMT) begin
			if (paudio != 16'd1) begin
				not_pcm = 1;
				phase = PH_STOP;
				return;
			end
			fmtf = pfields;
			fseen = 1;
		end else if (kind == K_DATA && dbits != 0) begin
			csum = psum;
			csamp = psamp;
			dpres = 1;
			dempty = (clen == 0);
		end
		tag = 0; clen = 0; cpos = 0; paudio = 0; pfields = 0;
		kind = K_OTHER;
		phase = PH_CHUNK_HDR;
	endtask

	task automatic open_chunk();
		kind = K_OTHER;
		if (tag == TAG_FMT && clen >= 16) begin
			kind = K_FMT;
		end else if (tag == TAG_DATA) begin
			kind = K_DATA;
			psum = 0;
			psamp = 0;
			dbits = fseen ? fmtf[63:48] : 16'd0;
			// A format was seen but its sample width is zero: nothing decodes.
			if (dbits == 0 && fseen) dbits = 16'hFFFF;
		end
		cpos = 0;
		phase = PH_BODY;
		if (chunk_span() == 0) close_chunk();
	endtask

	task automatic body_byte(input logic [7:0] b);
		logic signed [15:0] h;
		longint             s;
		logic               got;
		got = 0;
		s = 0;
		if (kind == K_FMT) begin
			if (cpos < 2) paudio |= 16'(b) << (8 * cpos);
			else if (cpos < 8) pfields |= 64'(b) << (8 * (cpos - 2));
			else if (cpos == 14 || cpos == 15) pfields |= 64'(b) << (48 + 8 * (cpos - 14));
		end else if (kind == K_DATA && cpos < 64'(clen)) begin
			if (dbits == 16'd8) begin
				s = (longint'(b) - 128) * 256;
				got = 1;
			end else if (dbits == 16'd16) begin
				if (!cpos[0]) begin
					lowh = b;
				end else begin
					h = {b, lowh};
					s = h;
					got = 1;
				end
			end
		end
		if (got) begin
			psum += 64'(s * s);
			psamp++;
		end
		cpos++;
		if (cpos == chunk_span()) close_chunk();
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [63:0] pos;
		pos = nbytes;
		if (ovl) return;
		if (nbytes >= CLIP_MAX) begin
			ovl = 1;
			return;
		end
		nbytes++;
		case (phase)
			PH_HEADER: begin
				tag = {tag[23:0], b};
				if (pos == 3 && tag != TAG_RIFF) hbad = 1;
				if (pos == 11) begin
					if (tag != TAG_WAVE) hbad = 1;
					tag = 0; cpos = 0; clen = 0;
					phase = PH_CHUNK_HDR;
				end
			end
			PH_CHUNK_HDR: begin
				if (cpos < 4) tag = {tag[23:0], b};
				else clen |= 32'(b) << (8 * (cpos - 4));
				cpos++;
				if (cpos == 8) open_chunk();
			end
			PH_BODY: body_byte(b);
			default: ;
		endcase
	endtask

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	task automatic finish_clip(input logic [2:0] cam);
		clip_report_t rep;
		logic [15:0]  chan, bits, prev;
		logic [31:0]  rate, w, mix;
		logic [63:0]  r;
		rep.score = 0;
		rep.detected = 0;
		rep.count = nbytes[23:0];
		chan = fmtf[15:0];
		rate = fmtf[47:16];
		bits = fmtf[63:48];
		if (ovl) rep.code = ERR_TOO_LONG;
		else if (nbytes < HDR_BYTES) rep.code = ERR_SHORT;
		else if (hbad) rep.code = ERR_NOT_WAVE;
		else if (not_pcm) rep.code = ERR_NOT_PCM;
		else if (!fseen || chan == 0 || rate == 0 || rate > 32'h7FFFFFFF ||
				(bits != 16'd8 && bits != 16'd16) || !dpres || dempty)
			rep.code = ERR_MISSING;
		else if (csamp == 0) rep.code = ERR_NO_SMPL;
		else rep.code = ERR_OK;
		if (rep.code == ERR_OK) begin
			r = root64((csum * 4) / csamp);
			rep.score = (r > 64'd65535) ? 16'hFFFF : r[15:0];
			prev = levels[cam];
			w = (weight > 9'd256) ? 32'd256 : 32'(weight);
			if (prev == 0) begin
				levels[cam] = rep.score;
				rep.detected = rep.score >= min_lvl;
			end else begin
				rep.detected = (rep.score >= min_lvl) &&
					(64'(rep.score) * 256 >= 64'(ratio) * 64'(prev));
				mix = (32'(prev) * (256 - w) + 32'(rep.score) * w + 128) >> 8;
				levels[cam] = mix[15:0];
			end
		end
		reports.push_back(rep);
		clear_clip();
	endtask

	always @(posedge clk or negedge arst_n) begin
		clip_report_t want;
		if (!arst_n) begin
			min_lvl = MIN_LEVEL_RST;
			ratio = SPIKE_RATIO_RST;
			weight = NEW_WEIGHT_RST;
			foreach (levels[i]) levels[i] = 0;
			reports.delete();
			clear_clip();
			nfail = 0;
			nchecked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MIN_LEVEL:   min_lvl = cfg_data;
					REG_SPIKE_RATIO: ratio = cfg_data;
					REG_NEW_WEIGHT:  weight = cfg_data[8:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (reports.size() == 0) begin
					$error("result transaction with no clip outstanding: %h", m_tdata);
					nfail++;
				end else begin
					want = reports.pop_front();
					nchecked++;
					if (m_tdata[15:0] !== want.score) begin
						$error("score: expected %0d, actual %0d", want.score, m_tdata[15:0]);
						nfail++;
					end
					if (m_tdata[16] !== want.detected) begin
						$error("detected: expected %0d, actual %0d", want.detected, m_tdata[16]);
						nfail++;
					end
					if (m_tdata[19:17] !== want.code) begin
						$error("error_code: expected %0d, actual %0d", want.code,
							m_tdata[19:17]);
						nfail++;
					end
					if (m_tdata[43:20] !== want.count) begin
						$error("byte_count: expected %0d, actual %0d", want.count,
							m_tdata[43:20]);
						nfail++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
				if (s_tlast) finish_clip(s_tuser);
			end
		end
		pending <= reports.size();
		fails <= nfail;
		checked <= nchecked;
	end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the WAV clip RMS spike detector: directed and random clips
// streamed with random gaps and result stalls under several threshold and
// weight settings, checked by a separate parsing checker.
// ----------------------------------------------------------------------------
module tb
	import wcrs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN = 100;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = 0;
	logic        s_tlast = 0;
	logic [2:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;

	int pending, fails, checked;
	int cycles = 0;
	int hold = 0;
	int bytes_sent = 0;
	int clips_sent = 0;
	logic calm = 0;
	logic [7:0] clip_q[$];

	wav_clip_rms_spike_detector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wav_clip_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fails(fails), .checked(checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("wav_clip_rms_spike_detector regression: fail");
			$finish;
		end
	end

	// Result stalls come in bursts of random length, timed by the hold counter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			hold <= 0;
		end else if (calm) begin
			m_tready <= 1;
		end else if (hold > 0) begin
			hold <= hold - 1;
		end else if (m_tready && $urandom_range(0, 7) == 0) begin
			m_tready <= 0;
			hold <= $urandom_range(0, 8);
		end else begin
			m_tready <= 1;
		end
	end

	task automatic put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--) clip_q.push_back(t[8*i +: 8]);
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) clip_q.push_back(v[8*i +: 8]);
	endtask

	task automatic put_header(input logic [31:0] riff);
		clip_q.delete();
		put_tag(riff);
		put_le($urandom, 4);
		put_tag(TAG_WAVE);
	endtask

	task automatic put_fmt(input int len, input logic [15:0] audio, input logic [15:0] chan,
			input logic [31:0] rate, input logic [15:0] bits);
		put_tag(TAG_FMT);
		put_le(len, 4);
		if (len >= 16) begin
			put_le(audio, 2);
			put_le(chan, 2);
			put_le(rate, 4);
			put_le($urandom, 4);
			put_le($urandom, 2);
			put_le(bits, 2);
			for (int i = 16; i < len; i++) clip_q.push_back($urandom);
		end else begin
			for (int i = 0; i < len; i++) clip_q.push_back($urandom);
		end
		if (len % 2) clip_q.push_back($urandom);
	endtask

	// Sample bytes with an amplitude of about 2^k; k of 8 or more gives
	// full-scale extremes of both signs.
	task automatic put_data(input int len, input int bits, input int k);
		logic [7:0] v;
		put_tag(TAG_DATA);
		put_le(len, 4);
		for (int i = 0; i < len; i++) begin
			if (k >= 8) v = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
			else v = 8'($urandom_range(0, (2 << k) - 1) - (1 << k));
			if (bits == 8) clip_q.push_back(v + 8'd128);
			else if (i % 2 == 0) clip_q.push_back(k >= 8 ? {8{v[0]}} : 8'($urandom));
			else clip_q.push_back(v);
		end
		if (len % 2) clip_q.push_back($urandom);
	endtask

	task automatic put_other();
		int len;
		len = $urandom_range(0, 7);
		put_tag($urandom);
		put_le(len, 4);
		repeat (len + len % 2) clip_q.push_back($urandom);
	endtask

	task automatic send_clip(input logic [2:0] cam);
		for (int i = 0; i < clip_q.size(); i++) begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= clip_q[i];
			s_tlast <= (i == clip_q.size() - 1);
			s_tuser <= cam;
			do @(posedge clk); while (!s_tready);
			bytes_sent++;
		end
		s_tvalid <= 0;
		s_tlast <= 0;
		clips_sent++;
	endtask

	task automatic gen_clip();
		int mode, bits, k;
		mode = $urandom_range(0, 99);
		bits = $urandom_range(0, 1) ? 16 : 8;
		k = $urandom_range(0, 8);
		if (mode < 8) begin
			clip_q.delete();
			repeat ($urandom_range(1, 60)) clip_q.push_back($urandom);
			return;
		end
		put_header(mode < 12 ? $urandom : TAG_RIFF);
		if ($urandom_range(0, 3) == 0) put_other();
		if (mode < 16) put_data($urandom_range(0, 8), bits, k);
		if ($urandom_range(0, 9) == 0) put_fmt($urandom_range(0, 15), 1, 1, 8000, bits);
		put_fmt($urandom_range(0, 4) == 0 ? 18 : 16,
			mode < 20 ? 16'($urandom) : 16'd1,
			mode < 24 ? 16'd0 : 16'($urandom_range(1, 2)),
			mode < 26 ? 32'd0 : (mode < 28 ? 32'h80000000 | $urandom : 32'd44100),
			mode < 32 ? 16'($urandom_range(0, 24)) : 16'(bits));
		if ($urandom_range(0, 3) == 0) put_other();
		put_data($urandom_range(0, 5) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 24),
			bits, k);
		if ($urandom_range(0, 4) == 0) put_data($urandom_range(1, 16), bits, k);
		// Cut off the tail now and then so the last chunk is incomplete.
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 6)) if (clip_q.size() > 1) void'(clip_q.pop_back());
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [15:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic apply_setting(input int n);
		case (n)
			0: begin
				cfg_write(REG_MIN_LEVEL, 0);
				cfg_write(REG_SPIKE_RATIO, 0);
				cfg_write(REG_NEW_WEIGHT, 0);
			end
			1: begin
				cfg_write(REG_MIN_LEVEL, 16'hFFFF);
				cfg_write(REG_SPIKE_RATIO, 16'hFFFF);
				cfg_write(REG_NEW_WEIGHT, 16'd256);
			end
			2: begin
				cfg_write(REG_MIN_LEVEL, $urandom_range(0, 20000));
				cfg_write(REG_SPIKE_RATIO, $urandom_range(200, 700));
				cfg_write(REG_NEW_WEIGHT, 16'h01FF);
			end
			3: begin
				cfg_write(REG_MIN_LEVEL, $urandom);
				cfg_write(REG_SPIKE_RATIO, $urandom);
				cfg_write(REG_NEW_WEIGHT, 16'hFE40);
			end
			4: begin
				cfg_write(REG_MIN_LEVEL, MIN_LEVEL_RST);
				cfg_write(REG_SPIKE_RATIO, SPIKE_RATIO_RST);
				cfg_write(REG_NEW_WEIGHT, 16'(NEW_WEIGHT_RST));
			end
			default: begin
				cfg_write(REG_MIN_LEVEL, $urandom_range(0, 8000));
				cfg_write(REG_SPIKE_RATIO, 16'd256);
				cfg_write(REG_NEW_WEIGHT, $urandom_range(1, 255));
			end
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Full-scale negative samples saturate the score and seed slot 0.
		put_header(TAG_RIFF);
		put_fmt(16, 1, 1, 44100, 16);
		put_tag(TAG_DATA);
		put_le(8, 4);
		repeat (4) put_le(16'h8000, 2);
		send_clip(0);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 2, 48000, 16);
		put_data(12, 16, 8);
		send_clip(0);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 1, 8000, 8);
		put_tag(TAG_DATA);
		put_le(3, 4);
		put_le(32'h80FF00, 3);
		clip_q.push_back(8'h00);
		send_clip(7);
		clip_q.delete();
		repeat (10) clip_q.push_back($urandom);
		send_clip(1);
		put_header(32'h52494658);
		put_fmt(16, 1, 1, 8000, 8);
		put_data(4, 8, 3);
		send_clip(2);
		put_header(TAG_RIFF);
		put_fmt(16, 3, 1, 8000, 16);
		put_data(4, 16, 3);
		send_clip(3);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 1, 8000, 16);
		put_data(0, 16, 3);
		send_clip(4);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 1, 8000, 16);
		put_data(1, 16, 3);
		send_clip(5);
		// Data ahead of the format chunk is ignored.
		put_header(TAG_RIFF);
		put_data(6, 16, 5);
		put_fmt(16, 1, 1, 8000, 16);
		send_clip(6);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 1, 8000, 12);
		put_data(6, 16, 5);
		send_clip(6);
		put_header(TAG_RIFF);
		put_fmt(16, 1, 0, 32'h80000000, 16);
		put_data(6, 16, 5);
		send_clip(6);
		// Short format chunk skipped, odd unknown chunk, truncated last data.
		put_header(TAG_RIFF);
		put_fmt(14, 5, 0, 0, 0);
		put_tag(32'h4C495354);
		put_le(3, 4);
		put_le(32'h123456, 4);
		put_fmt(16, 1, 1, 8000, 8);
		put_data(5, 8, 6);
		put_data(9, 8, 2);
		repeat (3) void'(clip_q.pop_back());
		send_clip(5);

		for (int c = 0; c < 42; c++) begin
			if (c % 7 == 0) begin
				settle();
				apply_setting(c / 7);
			end
			if (c >= 35) calm = 1;
			gen_clip();
			send_clip($urandom);
		end

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Streamed %0d clips (%0d bytes) over six register settings; %0d results checked.",
			clips_sent, bytes_sent, checked);
		if (fails == 0) begin
			$display("wav_clip_rms_spike_detector regression: pass");
		end else begin
			$display("wav_clip_rms_spike_detector regression: fail");
		end
		$finish;
	end

endmodule
